// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the positional list engine.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/plist_pkg.sv =====
// Package for the positional list engine: sizes, codes, FSM and decode types.
// No dependencies; used by plist_decode and positional_list_engine_top.
package plist_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READOUT   = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_INSERT,
        K_DELETE,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        status_t            status;
    } dec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SH_RD,
        S_SH_WR,
        S_PLACE,
        S_RESP,
        S_RO_RD,
        S_RO_EMIT
    } state_t;

endpackage

// ===== design/plist_decode.sv =====
// Decodes a registered command against the current list length: target index,
// kind of work and early status. Depends on plist_pkg.
module plist_decode
    import plist_pkg::*;
(
    input  op_t                 opcode,
    input  logic signed [31:0]  position,
    input  logic [CNT_W-1:0]    len,
    output dec_t                dec
);

    logic               empty;
    logic               full;
    logic               pos_one;
    logic               pos_low;
    logic               pos_past_ins;
    logic               pos_past_del;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   len_idx;
    logic [IDX_W-1:0]   last_idx;
    logic signed [31:0] len_s;
    logic signed [31:0] len_p1_s;

    always_comb
    begin
        empty        = (len == '0);
        full         = (len == CNT_W'(CAPACITY));
        len_s        = $signed(32'(len));
        len_p1_s     = len_s + 32'sd1;
        pos_one      = (position == 32'sd1);
        pos_low      = (position <= 32'sd0);
        pos_past_ins = (position > len_p1_s);
        pos_past_del = (position > len_s);
        // only used where 2 <= position <= len+1, so it fits the index
        pos_idx      = IDX_W'(position - 32'sd1);
        len_idx      = IDX_W'(len);
        last_idx     = IDX_W'(len - CNT_W'(1));
    end

    always_comb
    begin
        dec.kind   = K_NONE;
        dec.idx    = '0;
        dec.status = ST_OK;
        case (opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
            begin
                if (full)
                begin
                    dec.status = ST_FULL;
                end
                else
                begin
                    dec.kind = K_INSERT;
                    if (opcode == OP_INS_BACK)
                        dec.idx = len_idx;
                    else if (opcode == OP_INS_POS && !empty && !pos_one)
                    begin
                        if (pos_low)
                            dec.idx = IDX_W'(1);
                        else if (pos_past_ins)
                            dec.idx = len_idx;
                        else
                            dec.idx = pos_idx;
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS:
            begin
                if (empty)
                begin
                    dec.status = ST_EMPTY;
                end
                else if (opcode == OP_DEL_FRONT)
                begin
                    dec.kind = K_DELETE;
                end
                else if (opcode == OP_DEL_BACK)
                begin
                    dec.kind = K_DELETE;
                    dec.idx  = last_idx;
                end
                else if (pos_one)
                begin
                    dec.kind = K_DELETE;
                end
                else if (pos_low || len == CNT_W'(1))
                begin
                    dec.status = ST_OOB;
                end
                else
                begin
                    dec.kind = K_DELETE;
                    dec.idx  = pos_past_del ? last_idx : pos_idx;
                end
            end
            OP_READOUT:
            begin
                if (empty)
                    dec.status = ST_EMPTY;
                else
                    dec.kind = K_READ;
            end
            default:
            begin
                dec.kind   = K_NONE;
                dec.status = ST_OK;
            end
        endcase
    end

endmodule

// ===== design/positional_list_engine_top.sv =====
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values in a single-port-write, registered-read memory, edited by a sequencer
// that moves one entry per shift read and shift write. A transaction is taken
// when start is high and busy is low; busy stays high until the last result
// has been shown. Results appear for exactly one cycle with result_strobe and
// cannot be held off. States from accept to the final result: an insert at
// index i has decode, a shift read and write per entry from i to the end, place
// and response; a delete at index i has decode, a shift read and write per
// entry after i, and response; a rejected command or no-op decode and response;
// a readout decode, then read and emit per entry; all use the shared memory port.
// Depends on plist_pkg, plist_decode and assert_macros.svh.
`include "assert_macros.svh"

module positional_list_engine_top
    import plist_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              opcode,
    input  logic signed [31:0]      value,
    input  logic signed [31:0]      position,
    output logic                    result_strobe,
    output logic [1:0]              status,
    output logic signed [31:0]      entry_value,
    output logic                    entry_valid,
    output logic [COUNT_W-1:0]      entry_count,
    output logic                    last_result
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic                ins_reg, ins_next;
    status_t             status_reg, status_next;
    op_t                 op_reg;
    logic signed [31:0]  value_reg;
    logic signed [31:0]  pos_reg;

    logic [DATA_W-1:0]   mem [CAPACITY];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;

    dec_t                dec;
    logic                accept;
    logic                ro_last;

    assign accept  = start && (state_reg == S_IDLE);
    assign ro_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == len_reg);

    plist_decode u_decode (
        .opcode   (op_reg),
        .position (pos_reg),
        .len      (len_reg),
        .dec      (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            ptr_reg    <= '0;
            tgt_reg    <= '0;
            ins_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ptr_reg    <= ptr_next;
            tgt_reg    <= tgt_next;
            ins_reg    <= ins_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(opcode);
            value_reg <= value;
            pos_reg   <= position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // next state and sequencer registers
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        tgt_next    = tgt_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                status_next = dec.status;
                tgt_next    = dec.idx;
                case (dec.kind)
                    K_INSERT:
                    begin
                        ins_next = 1'b1;
                        ptr_next = IDX_W'(len_reg);
                        state_next = (IDX_W'(len_reg) == dec.idx) ? S_PLACE : S_SH_RD;
                    end
                    K_DELETE:
                    begin
                        ins_next = 1'b0;
                        ptr_next = dec.idx;
                        len_next = len_reg - CNT_W'(1);
                        // removing the last entry needs no shifting
                        state_next = (CNT_W'(dec.idx) == len_reg - CNT_W'(1)) ?
                                     S_RESP : S_SH_RD;
                    end
                    K_READ:
                    begin
                        ptr_next   = '0;
                        state_next = S_RO_RD;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                if (ins_reg)
                begin
                    ptr_next   = ptr_reg - IDX_W'(1);
                    state_next = (ptr_reg - IDX_W'(1) == tgt_reg) ? S_PLACE : S_SH_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = (CNT_W'(ptr_reg) + CNT_W'(1) == len_reg) ?
                                 S_RESP : S_SH_RD;
                end
            end
            S_PLACE:
            begin
                len_next   = len_reg + CNT_W'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            S_RO_RD:
            begin
                state_next = S_RO_EMIT;
            end
            S_RO_EMIT:
            begin
                ptr_next   = ptr_reg + IDX_W'(1);
                state_next = ro_last ? S_IDLE : S_RO_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory control and result ports
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        rd_addr       = ptr_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = rd_data_reg;
        result_strobe = 1'b0;
        status        = ST_OK;
        entry_value   = '0;
        entry_valid   = 1'b0;
        entry_count   = COUNT_W'(len_reg);
        last_result   = 1'b0;
        case (state_reg)
            S_SH_RD:
            begin
                rd_addr = ins_reg ? ptr_reg - IDX_W'(1) : ptr_reg + IDX_W'(1);
            end
            S_SH_WR:
            begin
                wr_en = 1'b1;
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = tgt_reg;
                wr_data = value_reg;
            end
            S_RESP:
            begin
                result_strobe = 1'b1;
                status        = status_reg;
                last_result   = 1'b1;
            end
            S_RO_EMIT:
            begin
                result_strobe = 1'b1;
                entry_value   = rd_data_reg;
                entry_valid   = 1'b1;
                last_result   = ro_last;
            end
            default:
            begin
                rd_addr = ptr_reg;
            end
        endcase
    end

    `ASSERT_NEVER(a_len_in_range, len_reg > CNT_W'(CAPACITY), "list length beyond capacity")
    `ASSERT_CLK(a_idle_after_last, result_strobe && last_result |=> !busy, "busy after final result")
    `ASSERT_NEVER(a_no_result_idle, !busy && result_strobe, "result strobe while idle")
    `ASSERT_CLK(a_place_grows, state_reg == S_PLACE |=> len_reg == $past(len_reg) + CNT_W'(1), "insert did not grow list")

endmodule

// ===== bench/tb_positional_list_engine_top.sv =====
// Testbench for positional_list_engine_top: directed and random list edits and readouts.
// It mirrors the list contents to predict each result and checks every strobed result.
// Depends on plist_pkg and the RTL of positional_list_engine_top.
`timescale 1ns / 1ps

module tb_positional_list_engine_top
    import plist_pkg::*;
();

    typedef struct {
        status_t               status;
        logic signed [31:0]    value;
        logic                  valid;
        logic [COUNT_W-1:0]    count;
        logic                  last;
    } list_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [2:0]             opcode = 3'd0;
    logic signed [31:0]     value = 32'sd0;
    logic signed [31:0]     position = 32'sd0;
    logic                   busy;
    logic                   result_strobe;
    logic [1:0]             status;
    logic signed [31:0]     entry_value;
    logic                   entry_valid;
    logic [COUNT_W-1:0]     entry_count;
    logic                   last_result;

    // mirror of the list held by the block
    logic signed [31:0]     mirror_entries [CAPACITY];
    int                     mirror_len = 0;
    list_result_t           awaited_results [$];

    int                     sender_gap_pct = 16;
    int                     error_count = 0;
    int                     transactions = 0;
    int                     results_checked = 0;
    int                     readouts = 0;
    int                     full_rejects = 0;
    int                     oob_rejects = 0;
    int                     empty_rejects = 0;

    positional_list_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .result_strobe (result_strobe),
        .status        (status),
        .entry_value   (entry_value),
        .entry_valid   (entry_valid),
        .entry_count   (entry_count),
        .last_result   (last_result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic status_t mirror_insert(int idx, logic signed [31:0] val);
        int i;
        if (mirror_len >= CAPACITY)
            return ST_FULL;
        if (idx > mirror_len)
            idx = mirror_len;
        for (i = mirror_len; i > idx; i--)
            mirror_entries[i] = mirror_entries[i - 1];
        mirror_entries[idx] = val;
        mirror_len++;
        return ST_OK;
    endfunction

    function automatic status_t mirror_remove(int idx);
        int i;
        if (mirror_len == 0)
            return ST_EMPTY;
        if (idx >= mirror_len)
            idx = mirror_len - 1;
        for (i = idx; i + 1 < mirror_len; i++)
            mirror_entries[i] = mirror_entries[i + 1];
        mirror_len--;
        return ST_OK;
    endfunction

    function automatic void await_result(status_t st, logic signed [31:0] val, logic vld,
                                         logic last);
        list_result_t r;
        r.status = st;
        r.value  = val;
        r.valid  = vld;
        r.count  = COUNT_W'(mirror_len);
        r.last   = last;
        awaited_results.push_back(r);
    endfunction

    // Applies one accepted transaction to the mirror and queues the results it causes.
    function automatic void predict_list_op(op_t op, logic signed [31:0] val,
                                            logic signed [31:0] pos);
        int      n;
        longint  p;
        status_t st;
        int      k;
        n  = mirror_len;
        p  = pos;
        st = ST_OK;
        case (op)
            OP_INS_FRONT: st = mirror_insert(0, val);
            OP_INS_BACK:  st = mirror_insert(n, val);
            OP_INS_POS:
            begin
                if (n == 0 || p == 1)
                    st = mirror_insert(0, val);
                else if (p <= 0)
                    st = mirror_insert(1, val);
                else if (p - 1 > longint'(n))
                    st = mirror_insert(n, val);
                else
                    st = mirror_insert(int'(p - 1), val);
            end
            OP_DEL_FRONT: st = mirror_remove(0);
            OP_DEL_BACK:  st = (n == 0) ? ST_EMPTY : mirror_remove(n - 1);
            OP_DEL_POS:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else if (p == 1)
                    st = mirror_remove(0);
                else if (p <= 0 || n == 1)
                    st = ST_OOB;
                else if (p - 1 > longint'(n - 1))
                    st = mirror_remove(n - 1);
                else
                    st = mirror_remove(int'(p - 1));
            end
            OP_READOUT:
            begin
                readouts++;
                if (n == 0)
                begin
                    empty_rejects++;
                    await_result(ST_EMPTY, 32'sd0, 1'b0, 1'b1);
                end
                else
                begin
                    for (k = 0; k < n; k++)
                        await_result(ST_OK, mirror_entries[k], 1'b1, k + 1 == n);
                end
                return;
            end
            default: st = ST_OK;
        endcase
        if (st == ST_FULL)
            full_rejects++;
        if (st == ST_OOB)
            oob_rejects++;
        if (st == ST_EMPTY)
            empty_rejects++;
        await_result(st, 32'sd0, 1'b0, 1'b1);
    endfunction

    // One transaction: optional idle gap, then hold start until busy is low at an edge.
    task automatic send_list_op(op_t op, logic signed [31:0] val, logic signed [31:0] pos);
        if ($urandom_range(1, 100) <= sender_gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_list_op(op, val, pos);
        transactions++;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && result_strobe)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d count %0d",
                         $time, status, entry_count);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", want.status, status);
                check_field("entry_value", want.value, entry_value);
                check_field("entry_valid", want.valid, entry_valid);
                check_field("entry_count", want.count, entry_count);
                check_field("last_result", want.last, last_result);
                results_checked++;
            end
        end
    end

    // Every delete flavour and readout against an empty list, plus the unused opcode.
    task automatic test_empty_list();
        send_list_op(OP_READOUT, 32'sd0, 32'sd0);
        send_list_op(OP_DEL_FRONT, 32'sd0, 32'sd0);
        send_list_op(OP_DEL_BACK, 32'sd0, 32'sd0);
        send_list_op(OP_DEL_POS, 32'sd0, 32'sd1);
        send_list_op(OP_NOP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    endtask

    task automatic test_insert_cases();
        // empty list takes any position
        send_list_op(OP_INS_POS, 32'sd11, 32'sh8000_0000);
        send_list_op(OP_INS_FRONT, 32'sh8000_0000, 32'sd0);
        send_list_op(OP_INS_BACK, 32'sh7FFF_FFFF, 32'sd0);
        send_list_op(OP_INS_POS, -32'sd1, 32'sd1);
        send_list_op(OP_INS_POS, 32'sd22, 32'sd0);
        send_list_op(OP_INS_POS, 32'sd33, 32'sh7FFF_FFFF);
        send_list_op(OP_INS_POS, 32'sd44, 32'sd3);
        send_list_op(OP_READOUT, 32'sd0, 32'sd0);
    endtask

    task automatic test_delete_cases();
        send_list_op(OP_DEL_POS, 32'sd0, 32'sd0);
        send_list_op(OP_DEL_POS, 32'sd0, 32'sh8000_0000);
        // beyond the end removes the last entry
        send_list_op(OP_DEL_POS, 32'sd0, 32'sh7FFF_FFFF);
        send_list_op(OP_DEL_POS, 32'sd0, 32'sd2);
        send_list_op(OP_DEL_FRONT, 32'sd0, 32'sd0);
        send_list_op(OP_DEL_BACK, 32'sd0, 32'sd0);
        while (mirror_len > 1)
            send_list_op(OP_DEL_FRONT, 32'sd0, 32'sd0);
        // single entry: only position 1 may delete
        send_list_op(OP_DEL_POS, 32'sd0, 32'sd2);
        send_list_op(OP_DEL_POS, 32'sd0, 32'sd1);
        send_list_op(OP_READOUT, 32'sd0, 32'sd0);
    endtask

    // Swings between filling and draining so the list repeatedly hits full and empty.
    task automatic test_random_traffic(int items, int gap_pct);
        int                 i;
        int                 r;
        int                 ins_share;
        bit                 filling;
        op_t                op;
        logic signed [31:0] val;
        logic signed [31:0] pos;
        sender_gap_pct = gap_pct;
        filling = (mirror_len < CAPACITY / 2);
        for (i = 0; i < items; i++)
        begin
            if (filling && mirror_len == CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && mirror_len == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            ins_share = filling ? 72 : 19;
            r = $urandom_range(0, 99);
            if (r < 8)
                op = OP_READOUT;
            else if (r < 11)
                op = OP_NOP;
            else if (r < 11 + ins_share)
                op = op_t'($urandom_range(OP_INS_FRONT, OP_INS_POS));
            else
                op = op_t'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));

            case ($urandom_range(0, 4))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                default: val = $urandom();
            endcase

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pos = $urandom_range(1, mirror_len + 2);
                5, 6:          pos = 32'sd0 - $urandom_range(0, 3);
                7, 8:          pos = $urandom();
                default:       pos = ($urandom_range(0, 1) == 0) ? 32'sh8000_0000
                                                                  : 32'sh7FFF_FFFF;
            endcase
            send_list_op(op, val, pos);
        end
    endtask

    initial
    begin
        int wait_cycles;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_cases();
        test_delete_cases();
        test_random_traffic(80, 16);
        test_random_traffic(80, 46);
        test_random_traffic(74, 0);

        start <= 1'b0;
        wait_cycles = 0;
        while (awaited_results.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (80) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected 0 outstanding, got %0d",
                     $time, awaited_results.size(), awaited_results.size());
            error_count += awaited_results.size();
        end

        $display("Ran %0d transactions, %0d results checked, %0d readouts", transactions,
                 results_checked, readouts);
        $display("Rejections seen: %0d list full, %0d out of bounds, %0d list empty",
                 full_rejects, oob_rejects, empty_rejects);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
